FILE: design/assert_macros.svh
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/tcw_pkg.sv
// Types and constants of the text console writer.
package tcw_pkg;

  localparam int REQ_W      = 2;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int LIN_W      = 11;
  localparam int MUL_W      = 12;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  localparam logic [7:0] CH_NL        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;

  typedef struct packed {
    logic [7:0] echo;
    logic [7:0] cchar;
    logic [7:0] cattr;
    logic       scroll;
    logic       status;
  } res_t;

endpackage

FILE: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/text_console_writer_unit.sv
// Text console writer: cursor, screen store and request sequencer.
//
// Text-mode console of SCREEN_WIDTH x SCREEN_HEIGHT cells held in one RAM
// (char in the low byte, attribute in the high byte). After reset a clearing
// pass writes a blank in attribute 7 to every cell, one per cycle, so input
// is held off until the pass is done. One request is worked at a time: the
// result word is loaded in ST_RESULT (after ST_READ for an in-range read
// cell), and the next request is taken once it is loaded. The result word
// waits in its register while the output is stalled. A put byte that scrolls
// (newline on the bottom row, or a print at the last cell) copies rows up
// through the single RAM write port, one cell a cycle, then blanks the bottom
// row. Its result word is loaded after the copy and the blank, and after
// ST_PUT when the printed byte is written after the scroll.
module text_console_writer_unit #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte[7:0], target_row[12:8], target_col[19:13]
  input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[1:0]
  input  logic [tcw_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cursor_row[4:0], cursor_col[11:5], cursor_linear[22:12], echo_byte[30:23],
  // cell_char[38:31], cell_attr[46:39], did_scroll[47], status[48]
  output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_wdata
);

  import tcw_pkg::*;

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(SCREEN_WIDTH * (SCREEN_HEIGHT - 1));
  localparam logic [ADDR_W-1:0] PUT_ADDR  = ADDR_W'(SCREEN_WIDTH * (SCREEN_HEIGHT - 1) - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_LIM   = ROW_W'(SCREEN_HEIGHT);
  localparam logic [COL_W-1:0]  COL_LIM   = COL_W'(SCREEN_WIDTH);
  localparam int PAD_W = OUT_DATA_W - (ROW_W + COL_W + LIN_W + 26);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_COPY, ST_BLANK, ST_PUT, ST_RESULT
  } state_t;

  function automatic logic [MUL_W-1:0] lin(input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c);
    lin = MUL_W'(r) * MUL_W'(SCREEN_WIDTH) + MUL_W'(c);
  endfunction

  state_t             state;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  cp_addr;
  logic               cp_valid;
  logic               put_pend;
  logic [7:0]         put_byte;
  logic [7:0]         text_color;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  res_t               res;
  res_t               res_next;

  logic [REQ_W-1:0]   req;
  logic [7:0]         in_byte;
  logic [ROW_W-1:0]   trow;
  logic [COL_W-1:0]   tcol;
  logic               in_range;
  logic               last_cell;
  logic [ROW_W-1:0]   bs_row;
  logic [COL_W-1:0]   bs_col;
  logic [MUL_W-1:0]   cur_lin;
  logic [MUL_W-1:0]   bs_lin;
  logic [MUL_W-1:0]   tgt_lin;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  rdata;

  assign req       = s_axis_tuser;
  assign in_byte   = s_axis_tdata[7:0];
  assign trow      = s_axis_tdata[12:8];
  assign tcol      = s_axis_tdata[19:13];
  assign in_range  = (trow < ROW_LIM) && (tcol < COL_LIM);
  assign last_cell = (cur_row == ROW_MAX) && (cur_col == COL_MAX);
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    bs_row = cur_row;
    bs_col = cur_col;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      bs_row = cur_row - 1'b1;
      bs_col = COL_MAX;
    end
  end

  assign cur_lin = lin(cur_row, cur_col);
  assign bs_lin  = lin(bs_row, bs_col);
  assign tgt_lin = lin(trow, tcol);

  always_comb begin
    res_next = '0;
    unique case (req)
      REQ_PUT: begin
        res_next.echo = in_byte;
        priority if (in_byte == CH_NL) begin
          res_next.scroll = (cur_row == ROW_MAX);
        end else if (in_byte == CH_CR || in_byte == CH_BS) begin
          res_next.scroll = 1'b0;
        end else begin
          res_next.scroll = last_cell;
        end
      end
      REQ_SET, REQ_READ: begin
        res_next.status = !in_range;
      end
      default: begin
        res_next.status = 1'b1;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {text_color, CH_SPACE};
    mem_raddr = idx + ROW_STEP;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {DEFAULT_ATTR, CH_SPACE};
      end
      ST_IDLE: begin
        mem_raddr = ADDR_W'(tgt_lin);
        if (s_axis_tvalid && req == REQ_PUT) begin
          if (in_byte == CH_BS) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(bs_lin);
          end else if (in_byte != CH_NL && in_byte != CH_CR && !last_cell) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cur_lin);
            mem_wdata = {text_color, in_byte};
          end
        end
      end
      ST_COPY: begin
        mem_we    = cp_valid;
        mem_waddr = cp_addr;
        mem_wdata = rdata;
      end
      ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = PUT_ADDR;
        mem_wdata = {text_color, put_byte};
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      idx           <= '0;
      cp_valid      <= 1'b0;
      put_pend      <= 1'b0;
      text_color    <= DEFAULT_ATTR;
      cur_row       <= '0;
      cur_col       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_color <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST_ADDR) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            res <= res_next;
            priority if (res_next.scroll) begin
              idx   <= '0;
              state <= ST_COPY;
            end else if (req == REQ_READ && in_range) begin
              state <= ST_READ;
            end else begin
              state <= ST_RESULT;
            end
            unique case (req)
              REQ_PUT: begin
                priority if (in_byte == CH_NL) begin
                  cur_col <= '0;
                  if (cur_row != ROW_MAX) begin
                    cur_row <= cur_row + 1'b1;
                  end else begin
                    put_pend <= 1'b0;
                  end
                end else if (in_byte == CH_CR) begin
                  cur_col <= '0;
                end else if (in_byte == CH_BS) begin
                  cur_row <= bs_row;
                  cur_col <= bs_col;
                end else begin
                  if (cur_col != COL_MAX) begin
                    cur_col <= cur_col + 1'b1;
                  end else if (cur_row != ROW_MAX) begin
                    cur_col <= '0;
                    cur_row <= cur_row + 1'b1;
                  end else begin
                    cur_col  <= '0;
                    put_pend <= 1'b1;
                    put_byte <= in_byte;
                  end
                end
              end
              REQ_SET: begin
                if (in_range) begin
                  cur_row <= trow;
                  cur_col <= tcol;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          res   <= {res.echo, rdata[7:0], rdata[15:8], res.scroll, res.status};
          state <= ST_RESULT;
        end
        ST_COPY: begin
          // read one row below, write back in the next cycle
          if (idx == COPY_END) begin
            cp_valid <= 1'b0;
            state    <= ST_BLANK;
          end else begin
            cp_addr  <= idx;
            cp_valid <= 1'b1;
            idx      <= idx + 1'b1;
          end
        end
        ST_BLANK: begin
          if (idx == LAST_ADDR) begin
            idx   <= '0;
            state <= put_pend ? ST_PUT : ST_RESULT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_PUT: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {PAD_W'(0), res.status, res.scroll, res.cattr, res.cchar,
                              res.echo, cur_lin[LIN_W-1:0], cur_col, cur_row};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
`include "assert_macros.svh"

module tcw_checker #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import tcw_pkg::*;

  logic [MUL_W-1:0] exp_lin;

  assign exp_lin = MUL_W'(m_axis_tdata[4:0]) * MUL_W'(SCREEN_WIDTH)
                 + MUL_W'(m_axis_tdata[11:5]);

  `ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))

  `ASSERT_NXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `ASSERT_IMP(a_cursor_range, clk, rst, m_axis_tvalid,
              (m_axis_tdata[4:0] < ROW_W'(SCREEN_HEIGHT)) &&
              (m_axis_tdata[11:5] < COL_W'(SCREEN_WIDTH)))

  `ASSERT_IMP(a_linear, clk, rst, m_axis_tvalid, m_axis_tdata[22:12] == exp_lin[LIN_W-1:0])

  `ASSERT_NXT_ALL(a_clear_after_reset, clk, rst, !s_axis_tready && !m_axis_tvalid)

endmodule

bind text_console_writer_unit tcw_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tcw_checker (.*);

FILE: test/console_checker.sv
// Screen and cursor mirror of the text console writer that checks every result word.
module console_checker #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [tcw_pkg::REQ_W-1:0]          s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [tcw_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_we,
  input  logic [7:0]                         cfg_wdata,
  output int unsigned                        outstanding,
  output int unsigned                        mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic [tcw_pkg::ROW_W-1:0] row;
    logic [tcw_pkg::COL_W-1:0] col;
    logic [tcw_pkg::LIN_W-1:0] lin;
    tcw_pkg::res_t             res;
  } cursor_word_t;

  logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [7:0]                 color;
  cursor_word_t               expected_words [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches = mismatches + 1;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - SCREEN_WIDTH; i++) screen[i] = screen[i + SCREEN_WIDTH];
    for (int i = CELLS - SCREEN_WIDTH; i < CELLS; i++) screen[i] = {color, tcw_pkg::CH_SPACE};
  endfunction

  function automatic cursor_word_t console_apply(input logic [1:0] req, input logic [7:0] b,
                                                 input logic [4:0] trow, input logic [6:0] tcol);
    cursor_word_t w;
    int prow;
    int pcol;
    w = '0;
    case (req)
      tcw_pkg::REQ_PUT: begin
        w.res.echo = b;
        if (b == tcw_pkg::CH_NL) begin
          if (row_q < SCREEN_HEIGHT - 1) begin
            row_q = row_q + 1'b1;
          end else begin
            scroll_screen();
            w.res.scroll = 1'b1;
          end
          col_q = '0;
        end else if (b == tcw_pkg::CH_CR) begin
          col_q = '0;
        end else if (b == tcw_pkg::CH_BS) begin
          if (col_q > 0) begin
            col_q = col_q - 1'b1;
          end else if (row_q > 0) begin
            row_q = row_q - 1'b1;
            col_q = tcw_pkg::COL_W'(SCREEN_WIDTH - 1);
          end
          screen[row_q * SCREEN_WIDTH + col_q] = {color, tcw_pkg::CH_SPACE};
        end else begin
          prow = int'(row_q);
          pcol = int'(col_q);
          if (col_q < SCREEN_WIDTH - 1) begin
            col_q = col_q + 1'b1;
          end else if (row_q < SCREEN_HEIGHT - 1) begin
            col_q = '0;
            row_q = row_q + 1'b1;
          end else begin
            // last cell: byte lands one row up after the scroll
            scroll_screen();
            w.res.scroll = 1'b1;
            col_q = '0;
            prow = SCREEN_HEIGHT - 2;
          end
          screen[prow * SCREEN_WIDTH + pcol] = {color, b};
        end
      end
      tcw_pkg::REQ_SET: begin
        if (trow < SCREEN_HEIGHT && tcol < SCREEN_WIDTH) begin
          row_q = trow;
          col_q = tcol;
        end else begin
          w.res.status = 1'b1;
        end
      end
      tcw_pkg::REQ_READ: begin
        if (trow < SCREEN_HEIGHT && tcol < SCREEN_WIDTH) begin
          w.res.cchar = screen[trow * SCREEN_WIDTH + tcol][7:0];
          w.res.cattr = screen[trow * SCREEN_WIDTH + tcol][15:8];
        end else begin
          w.res.status = 1'b1;
        end
      end
      default: w.res.status = 1'b1;
    endcase
    w.row = row_q;
    w.col = col_q;
    w.lin = tcw_pkg::LIN_W'(row_q * SCREEN_WIDTH + col_q);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    cursor_word_t want;
    if (rst) begin
      color = tcw_pkg::DEFAULT_ATTR;
      row_q = '0;
      col_q = '0;
      for (int i = 0; i < CELLS; i++) screen[i] = {tcw_pkg::DEFAULT_ATTR, tcw_pkg::CH_SPACE};
      expected_words.delete();
    end else begin
      if (cfg_we) color = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word 0x%0h with nothing expected", m_tdata));
        end else begin
          want = expected_words.pop_front();
          compare_field("cursor_row", m_tdata[4:0], want.row);
          compare_field("cursor_col", m_tdata[11:5], want.col);
          compare_field("cursor_linear", m_tdata[22:12], want.lin);
          compare_field("echo_byte", m_tdata[30:23], want.res.echo);
          compare_field("cell_char", m_tdata[38:31], want.res.cchar);
          compare_field("cell_attr", m_tdata[46:39], want.res.cattr);
          compare_field("did_scroll", m_tdata[47], want.res.scroll);
          compare_field("status", m_tdata[48], want.res.status);
        end
      end
      if (s_tvalid && s_tready)
        expected_words.push_back(console_apply(s_tuser, s_tdata[7:0], s_tdata[12:8],
                                               s_tdata[19:13]));
    end
    outstanding <= expected_words.size();
  end

endmodule

FILE: test/tb_top.sv
// Top of the text console writer testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam logic [tcw_pkg::REQ_W-1:0] REQ_BAD = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [tcw_pkg::REQ_W-1:0]       s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_we = 1'b0;
  logic [7:0]                      cfg_wdata = tcw_pkg::DEFAULT_ATTR;

  int unsigned outstanding;
  int unsigned mismatches;
  int          send_idle = 29;
  int          recv_idle = 70;
  int          phase = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_writer_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  console_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  // result side: random stalls, one long hold-off at the start of the last phase
  initial begin : result_ready
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 3 && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_word(input logic [1:0] req, input logic [7:0] b,
                           input logic [4:0] row, input logic [6:0] col);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0000, col, row, b};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_color(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int         pick;
    int         sub;
    logic [7:0] b;
    logic [4:0] row;
    logic [6:0] col;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    b    = 8'($urandom_range(0, 255));
    row  = 5'($urandom_range(0, 31));
    col  = 7'($urandom_range(0, 127));
    if (pick < 50) begin
      if (sub < 12) b = tcw_pkg::CH_NL;
      else if (sub < 18) b = tcw_pkg::CH_CR;
      else if (sub < 26) b = tcw_pkg::CH_BS;
      send_word(tcw_pkg::REQ_PUT, b, row, col);
    end else if (pick < 95) begin
      // mostly on-screen targets, leaning to the bottom row and last column
      if (sub < 85) begin
        if ($urandom_range(0, 2) == 0) row = 5'(SCREEN_HEIGHT - 1);
        else row = 5'($urandom_range(0, SCREEN_HEIGHT - 1));
        if ($urandom_range(0, 3) == 0) col = 7'(SCREEN_WIDTH - 1);
        else col = 7'($urandom_range(0, SCREEN_WIDTH - 1));
      end
      if (pick < 68) send_word(tcw_pkg::REQ_SET, b, row, col);
      else send_word(tcw_pkg::REQ_READ, b, row, col);
    end else begin
      send_word(REQ_BAD, b, row, col);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset screen, range edges, controls, wraps and scrolls
    send_word(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)), 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)), 5'd24, 7'd79);
    send_word(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)), 5'd25, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'($urandom_range(0, 255)), 5'd0, 7'd80);
    send_word(tcw_pkg::REQ_READ, 8'hff, 5'd31, 7'd127);
    send_word(REQ_BAD, 8'hff, 5'd31, 7'd127);
    send_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_PUT, 8'h00, 5'd31, 7'd127);
    send_word(tcw_pkg::REQ_PUT, 8'hff, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);
    send_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_CR, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NL, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_BS, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd79);
    send_word(tcw_pkg::REQ_SET, 8'h00, 5'd25, 7'd0);
    send_word(tcw_pkg::REQ_SET, 8'h00, 5'd0, 7'd80);
    send_word(tcw_pkg::REQ_SET, 8'hff, 5'd31, 7'd127);
    send_word(tcw_pkg::REQ_SET, 8'h00, 5'd24, 7'd79);
    send_word(tcw_pkg::REQ_PUT, 8'h5a, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'h00, 5'd23, 7'd79);
    send_word(tcw_pkg::REQ_PUT, tcw_pkg::CH_NL, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_READ, 8'h00, 5'd24, 7'd0);
    send_word(tcw_pkg::REQ_SET, 8'h00, 5'd0, 7'd0);
    send_word(tcw_pkg::REQ_PUT, 8'h41, 5'd0, 7'd0);

    write_color(8'h00);
    repeat (100) random_word();

    send_idle = 70;
    recv_idle = 29;
    write_color(8'hff);
    phase = 2;
    repeat (100) random_word();

    send_idle = 0;
    recv_idle = 0;
    write_color(8'($urandom_range(1, 254)));
    phase = 3;
    repeat (100) random_word();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_unit.sv
design/tcw_checker.sv
test/console_checker.sv
test/tb_top.sv
